### sv/jsu_pkg.sv
// Shared types and the UTF-8 encoder for the JSON string unescape block.
`timescale 1ns / 1ps

package jsu_pkg;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_CLOSED   = 2'd1,
		KIND_NO_QUOTE = 2'd2,
		KIND_UNTERM   = 2'd3
	} kind_t;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LC_N      = 8'h6E;
	localparam logic [7:0] CH_LC_R      = 8'h72;
	localparam logic [7:0] CH_LC_T      = 8'h74;
	localparam logic [7:0] CH_LC_B      = 8'h62;
	localparam logic [7:0] CH_LC_F      = 8'h66;
	localparam logic [7:0] CH_LC_U      = 8'h75;

	localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
	localparam logic [20:0] SUPP_BASE     = 21'h10000;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last_of_run;
	} out_word_t;

	// All result words caused by one input word: data bytes first, then an
	// optional status word (tail of KIND_DATA means there is none).
	typedef struct packed {
		logic [5:0][7:0] bytes;
		logic [2:0]      nbytes;
		kind_t           tail;
	} run_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} utf8_t;

	function automatic utf8_t utf8_encode(input logic [20:0] c);
		utf8_t r;
		r = '0;
		if (c < 21'h80) begin
			r.b[0] = c[7:0];
			r.n = 3'd1;
		end else if (c < 21'h800) begin
			r.b[0] = {3'b110, c[10:6]};
			r.b[1] = {2'b10, c[5:0]};
			r.n = 3'd2;
		end else if (c < 21'h10000) begin
			r.b[0] = {4'b1110, c[15:12]};
			r.b[1] = {2'b10, c[11:6]};
			r.b[2] = {2'b10, c[5:0]};
			r.n = 3'd3;
		end else begin
			r.b[0] = {5'b11110, c[20:18]};
			r.b[1] = {2'b10, c[17:12]};
			r.b[2] = {2'b10, c[11:6]};
			r.b[3] = {2'b10, c[5:0]};
			r.n = 3'd4;
		end
		return r;
	endfunction

endpackage

### sv/jsu_front.sv
// Front end: parser state machine that turns each input word into a run of result words.
`timescale 1ns / 1ps

module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  jsu_pkg::in_word_t item,
	output logic              run_wr,
	output jsu_pkg::run_t     run
);

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_STR     = 7'b0000010,
		PH_ESC     = 7'b0000100,
		PH_HEX     = 7'b0001000,
		PH_PAIR_BS = 7'b0010000,
		PH_PAIR_U  = 7'b0100000,
		PH_LOW_HEX = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] hex_value_q, hex_value_d;
	logic        hex_invalid_q, hex_invalid_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [9:0]  pending_q, pending_d;

	logic [7:0]  b;
	logic        eoi;
	logic [3:0]  digit;
	logic        digit_bad;
	logic [15:0] hv_next;
	logic        inv_next;
	logic        hex_done;
	logic [15:0] code16;

	logic        pfx;
	logic        use_code;
	logic [20:0] code;
	logic        raw_en;
	logic [7:0]  raw_b;
	jsu_pkg::kind_t tail;
	jsu_pkg::utf8_t main_enc;
	jsu_pkg::utf8_t pend_enc;

	function automatic logic [7:0] esc_map(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c == jsu_pkg::CH_LC_N) r = 8'h0A;
		else if (c == jsu_pkg::CH_LC_R) r = 8'h0D;
		else if (c == jsu_pkg::CH_LC_T) r = 8'h09;
		else if (c == jsu_pkg::CH_LC_B) r = 8'h08;
		else if (c == jsu_pkg::CH_LC_F) r = 8'h0C;
		return r;
	endfunction

	assign b   = item.in_byte;
	assign eoi = item.end_of_input;

	always_comb begin
		digit = 4'd0;
		digit_bad = 1'b0;
		if (b >= 8'h30 && b <= 8'h39) begin
			digit = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			digit = 4'(b[3:0] + 4'd9);
		end else begin
			digit_bad = 1'b1;
		end
	end

	assign hv_next  = {hex_value_q[11:0], digit};
	assign inv_next = hex_invalid_q | digit_bad;
	assign hex_done = (hex_count_q == 2'd3);
	assign code16   = inv_next ? 16'h0000 : hv_next;

	always_comb begin
		phase_d = phase_q;
		hex_value_d = hex_value_q;
		hex_invalid_d = hex_invalid_q;
		hex_count_d = hex_count_q;
		pending_d = pending_q;
		pfx = 1'b0;
		use_code = 1'b0;
		code = 21'd0;
		raw_en = 1'b0;
		raw_b = 8'h00;
		tail = jsu_pkg::KIND_DATA;

		unique case (phase_q)
			PH_STR, PH_PAIR_BS: begin
				if (phase_q == PH_PAIR_BS && b == jsu_pkg::CH_BACKSLASH) begin
					phase_d = PH_PAIR_U;
				end else begin
					pfx = (phase_q == PH_PAIR_BS);
					if (b == jsu_pkg::CH_QUOTE) begin
						tail = jsu_pkg::KIND_CLOSED;
						phase_d = PH_IDLE;
					end else if (b == jsu_pkg::CH_BACKSLASH) begin
						phase_d = PH_ESC;
					end else begin
						raw_en = 1'b1;
						raw_b = b;
						phase_d = PH_STR;
					end
				end
			end
			PH_ESC, PH_PAIR_U: begin
				if (b == jsu_pkg::CH_LC_U) begin
					hex_value_d = 16'h0000;
					hex_invalid_d = 1'b0;
					hex_count_d = 2'd0;
					phase_d = (phase_q == PH_ESC) ? PH_HEX : PH_LOW_HEX;
				end else begin
					pfx = (phase_q == PH_PAIR_U);
					raw_en = 1'b1;
					raw_b = esc_map(b);
					phase_d = PH_STR;
				end
			end
			PH_HEX, PH_LOW_HEX: begin
				hex_value_d = hv_next;
				hex_invalid_d = inv_next;
				hex_count_d = 2'(hex_count_q + 2'd1);
				if (hex_done) begin
					if (phase_q == PH_LOW_HEX && code16[15:10] == jsu_pkg::LOW_SURR_TAG) begin
						use_code = 1'b1;
						code = 21'({pending_q, code16[9:0]}) + jsu_pkg::SUPP_BASE;
						phase_d = PH_STR;
					end else begin
						pfx = (phase_q == PH_LOW_HEX);
						if (code16[15:10] == jsu_pkg::HIGH_SURR_TAG) begin
							pending_d = code16[9:0];
							phase_d = PH_PAIR_BS;
						end else begin
							use_code = 1'b1;
							code = 21'(code16);
							phase_d = PH_STR;
						end
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (b == jsu_pkg::CH_QUOTE) begin
					if (eoi) tail = jsu_pkg::KIND_UNTERM;
					else phase_d = PH_STR;
				end else begin
					tail = jsu_pkg::KIND_NO_QUOTE;
				end
			end
		endcase

		// The last word of the buffer arrived inside an open string.
		if (eoi && phase_q != PH_IDLE && phase_d != PH_IDLE) begin
			pfx = 1'b0;
			use_code = 1'b0;
			raw_en = 1'b0;
			tail = jsu_pkg::KIND_UNTERM;
			phase_d = PH_IDLE;
			hex_value_d = 16'h0000;
			hex_invalid_d = 1'b0;
			hex_count_d = 2'd0;
			pending_d = 10'd0;
		end
	end

	always_comb begin
		pend_enc = jsu_pkg::utf8_encode({5'd0, jsu_pkg::HIGH_SURR_TAG, pending_q});
		main_enc = '0;
		if (use_code) begin
			main_enc = jsu_pkg::utf8_encode(code);
		end else if (raw_en) begin
			main_enc.b[0] = raw_b;
			main_enc.n = 3'd1;
		end
		run = '0;
		run.tail = tail;
		if (pfx) begin
			run.bytes[2:0] = pend_enc.b[2:0];
			run.bytes[5:3] = main_enc.b[2:0];
			run.nbytes = 3'(3'd3 + main_enc.n);
		end else begin
			run.bytes[3:0] = main_enc.b;
			run.nbytes = main_enc.n;
		end
	end

	assign run_wr = accept && (run.nbytes != 3'd0 || run.tail != jsu_pkg::KIND_DATA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_value_q <= 16'h0000;
			hex_invalid_q <= 1'b0;
			hex_count_q <= 2'd0;
			pending_q <= 10'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			hex_value_q <= hex_value_d;
			hex_invalid_q <= hex_invalid_d;
			hex_count_q <= hex_count_d;
			pending_q <= pending_d;
		end
	end

endmodule

### sv/jsu_fifo.sv
// Short queue of decoded runs between the parser and the output sequencer.
`timescale 1ns / 1ps

module jsu_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  jsu_pkg::run_t wr_run,
	output logic          full,
	output logic          head_valid,
	output jsu_pkg::run_t head,
	input  logic          rd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::run_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : AW'(wp_q + 1'b1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : AW'(rp_q + 1'b1);
			if (wr && !rd) count_q <= CW'(count_q + 1'b1);
			else if (rd && !wr) count_q <= CW'(count_q - 1'b1);
		end
	end

endmodule

### sv/jsu_back.sv
// Back end: steps through each queued run and hands out one result word per cycle while the receiver pops.
`timescale 1ns / 1ps

module jsu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  jsu_pkg::run_t      head,
	output logic               head_rd,
	output logic               empty,
	input  logic               pop,
	output jsu_pkg::out_word_t result
);

	logic [2:0]         idx_q;
	logic [2:0]         total;
	logic               last;
	logic               take;
	logic               valid_q;
	jsu_pkg::out_word_t sel;
	jsu_pkg::out_word_t result_q;

	assign total = 3'(head.nbytes + {2'd0, head.tail != jsu_pkg::KIND_DATA});
	assign last  = (idx_q == 3'(total - 3'd1));
	assign take  = head_valid && (!valid_q || pop);
	assign head_rd = take && last;

	always_comb begin
		sel.last_of_run = last;
		if (idx_q < head.nbytes) begin
			sel.out_byte = head.bytes[idx_q];
			sel.kind = jsu_pkg::KIND_DATA;
		end else begin
			sel.out_byte = 8'h00;
			sel.kind = head.tail;
		end
	end

	always_ff @(posedge clk) begin
		if (take) result_q <= sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q <= last ? 3'd0 : 3'(idx_q + 3'd1);
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	assign empty  = !valid_q;
	assign result = result_q;

endmodule

### sv/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper that emits UTF-8.
//
//   channel  handshake       payload
//   input    push / full     item   : in_byte, end_of_input
//   result   pop  / empty    result : out_byte, kind, last_of_run
//
// One input word is taken per cycle while the run queue has room.
// Each input word yields up to six result words, delivered one per cycle by
// the output sequencer while the receiver pops; the run queue (QUEUE_DEPTH
// entries) absorbs the bursts that one word can cause.
// Results of a taken word pass through the run queue and then the output register.
// Reset puts the parser back to waiting for an opening quote and empties the queue.
`timescale 1ns / 1ps

module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  jsu_pkg::in_word_t  item,
	output logic               empty,
	input  logic               pop,
	output jsu_pkg::out_word_t result
);

	logic          accept;
	logic          run_wr;
	jsu_pkg::run_t run;
	logic          head_valid;
	jsu_pkg::run_t head;
	logic          head_rd;

	assign accept = push && !full;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.run_wr (run_wr),
		.run    (run)
	);

	jsu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (run_wr),
		.wr_run     (run),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.rd         (head_rd)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_rd    (head_rd),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

### tb/json_string_unescape_utf8_test.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module json_string_unescape_utf8_test;

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [3:0] {
		P_IDLE,
		P_STR,
		P_ESC,
		P_HEX,
		P_PAIR_BS,
		P_PAIR_U,
		P_LOW_HEX
	} parse_phase_t;

	localparam logic [7:0]  CTRL_LF     = 8'h0A;
	localparam logic [7:0]  CTRL_CR     = 8'h0D;
	localparam logic [7:0]  CTRL_TAB    = 8'h09;
	localparam logic [7:0]  CTRL_BS     = 8'h08;
	localparam logic [7:0]  CTRL_FF     = 8'h0C;
	localparam logic [7:0]  CH_SLASH    = 8'h2F;
	localparam logic [15:0] HIGH_FIRST  = 16'hD800;
	localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST   = 16'hDC00;
	localparam logic [15:0] LOW_LAST    = 16'hDFFF;
	localparam int          MAX_RUN     = 6;
	localparam int          RANDOM_ITEMS = 260;
	localparam int          LONG_HOLD   = 300;
	localparam int          DRAIN_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	jsu_pkg::in_word_t  item;
	logic               empty;
	logic               pop;
	jsu_pkg::out_word_t result;

	json_string_unescape_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	parse_phase_t ph = P_IDLE;
	logic [15:0] hex_acc = '0;
	logic        hex_bad = 1'b0;
	logic [1:0]  hex_n = '0;
	logic [15:0] high_half = '0;

	jsu_pkg::out_word_t run_words[$];
	jsu_pkg::out_word_t due_words[$];

	int errors = 0;
	int burst_left = 0;
	bit no_gaps = 1'b0;
	bit hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(3_000_000);
		$display("FAIL");
		$finish;
	end

	function automatic void emit(input logic [7:0] b, input jsu_pkg::kind_t k);
		jsu_pkg::out_word_t w;
		w.out_byte = b;
		w.kind = k;
		w.last_of_run = 1'b0;
		if (run_words.size() < MAX_RUN)
			run_words.insert(run_words.size(), w);
	endfunction

	function automatic void put_code(input logic [20:0] c);
		if (c < 21'h80) begin
			emit(c[7:0], jsu_pkg::KIND_DATA);
		end else if (c < 21'h800) begin
			emit(8'hC0 | c[10:6], jsu_pkg::KIND_DATA);
			emit(8'h80 | c[5:0], jsu_pkg::KIND_DATA);
		end else if (c < 21'h10000) begin
			emit(8'hE0 | c[15:12], jsu_pkg::KIND_DATA);
			emit(8'h80 | c[11:6], jsu_pkg::KIND_DATA);
			emit(8'h80 | c[5:0], jsu_pkg::KIND_DATA);
		end else begin
			emit(8'hF0 | c[20:18], jsu_pkg::KIND_DATA);
			emit(8'h80 | c[17:12], jsu_pkg::KIND_DATA);
			emit(8'h80 | c[11:6], jsu_pkg::KIND_DATA);
			emit(8'h80 | c[5:0], jsu_pkg::KIND_DATA);
		end
	endfunction

	function automatic void start_hex(input parse_phase_t next_ph);
		hex_acc = '0;
		hex_bad = 1'b0;
		hex_n = '0;
		ph = next_ph;
	endfunction

	// Returns 1 when the fourth digit of the escape has arrived.
	function automatic bit take_digit(input logic [7:0] b);
		logic [7:0] d;
		d = '0;
		if (b >= "0" && b <= "9")
			d = b - "0";
		else if (b >= "a" && b <= "f")
			d = b - "a" + 8'd10;
		else if (b >= "A" && b <= "F")
			d = b - "A" + 8'd10;
		else
			hex_bad = 1'b1;
		hex_acc = {hex_acc[11:0], d[3:0]};
		if (hex_n == 2'd3) begin
			hex_n = '0;
			return 1'b1;
		end
		hex_n = hex_n + 2'd1;
		return 1'b0;
	endfunction

	function automatic void finish_escape(input logic [15:0] code);
		if (code >= HIGH_FIRST && code <= HIGH_LAST) begin
			high_half = code;
			ph = P_PAIR_BS;
		end else begin
			put_code({5'd0, code});
			ph = P_STR;
		end
	endfunction

	function automatic void string_char(input logic [7:0] b);
		if (b == jsu_pkg::CH_QUOTE) begin
			emit(8'h00, jsu_pkg::KIND_CLOSED);
			ph = P_IDLE;
		end else if (b == jsu_pkg::CH_BACKSLASH) begin
			ph = P_ESC;
		end else begin
			emit(b, jsu_pkg::KIND_DATA);
			ph = P_STR;
		end
	endfunction

	function automatic void escape_char(input logic [7:0] b);
		ph = P_STR;
		case (b)
			jsu_pkg::CH_LC_N: emit(CTRL_LF, jsu_pkg::KIND_DATA);
			jsu_pkg::CH_LC_R: emit(CTRL_CR, jsu_pkg::KIND_DATA);
			jsu_pkg::CH_LC_T: emit(CTRL_TAB, jsu_pkg::KIND_DATA);
			jsu_pkg::CH_LC_B: emit(CTRL_BS, jsu_pkg::KIND_DATA);
			jsu_pkg::CH_LC_F: emit(CTRL_FF, jsu_pkg::KIND_DATA);
			jsu_pkg::CH_LC_U: start_hex(P_HEX);
			default: emit(b, jsu_pkg::KIND_DATA);
		endcase
	endfunction

	// Advances the parser by one accepted word and queues the words it causes.
	function automatic void unescape_step(input jsu_pkg::in_word_t w);
		logic [7:0]         b;
		bit                 eoi;
		logic [15:0]        low;
		jsu_pkg::out_word_t tail;
		b = w.in_byte;
		eoi = w.end_of_input;
		run_words.delete();
		case (ph)
			P_STR: string_char(b);
			P_ESC: escape_char(b);
			P_HEX: begin
				if (take_digit(b))
					finish_escape(hex_bad ? 16'h0000 : hex_acc);
			end
			P_PAIR_BS: begin
				if (b == jsu_pkg::CH_BACKSLASH) begin
					ph = P_PAIR_U;
				end else begin
					put_code({5'd0, high_half});
					string_char(b);
				end
			end
			P_PAIR_U: begin
				if (b == jsu_pkg::CH_LC_U) begin
					start_hex(P_LOW_HEX);
				end else begin
					put_code({5'd0, high_half});
					escape_char(b);
				end
			end
			P_LOW_HEX: begin
				if (take_digit(b)) begin
					low = hex_bad ? 16'h0000 : hex_acc;
					if (low >= LOW_FIRST && low <= LOW_LAST) begin
						put_code({1'b0, high_half[9:0], low[9:0]} + 21'h10000);
						ph = P_STR;
					end else begin
						put_code({5'd0, high_half});
						finish_escape(low);
					end
				end
			end
			default: begin
				ph = P_IDLE;
				if (b == jsu_pkg::CH_QUOTE) begin
					if (eoi)
						emit(8'h00, jsu_pkg::KIND_UNTERM);
					else
						ph = P_STR;
				end else begin
					emit(8'h00, jsu_pkg::KIND_NO_QUOTE);
				end
				eoi = 1'b0;
			end
		endcase
		if (eoi && ph != P_IDLE) begin
			run_words.delete();
			emit(8'h00, jsu_pkg::KIND_UNTERM);
			ph = P_IDLE;
			hex_acc = '0;
			hex_bad = 1'b0;
			hex_n = '0;
			high_half = '0;
		end
		if (run_words.size() > 0) begin
			tail = run_words.pop_back();
			tail.last_of_run = 1'b1;
			run_words.insert(run_words.size(), tail);
		end
		due_words = {due_words, run_words};
	endfunction

	// Result checker: a word shown at a falling edge with pop high and empty low
	// is taken at the next rising edge.
	always @(negedge clk) begin
		jsu_pkg::out_word_t want;
		if (arst_n && pop && !empty) begin
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word: byte %02h kind %0d last %0b",
					$time, result.out_byte, result.kind, result.last_of_run);
				errors++;
			end else begin
				want = due_words.pop_front();
				if (result !== want) begin
					$display("%0t: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
						$time, want.out_byte, want.kind, want.last_of_run,
						result.out_byte, result.kind, result.last_of_run);
					errors++;
				end
			end
		end
	end

	// Receiver: switches between random stall patterns; a long hold on request.
	initial begin
		int mode;
		int mode_left;
		int tick;
		pop <= 1'b0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			tick++;
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ((tick % 7) < 5);
				endcase
			end
		end
	end

	task automatic send_word(input jsu_pkg::in_word_t w);
		int gap;
		if (!no_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		push <= 1'b1;
		item <= w;
		do @(negedge clk); while (full);
		@(posedge clk);
		unescape_step(w);
	endtask

	task automatic send_bytes(input byte_q_t q, input bit eoi_last);
		jsu_pkg::in_word_t w;
		foreach (q[i]) begin
			w.in_byte = q[i];
			w.end_of_input = eoi_last && (i == q.size() - 1);
			send_word(w);
		end
	endtask

	task automatic send_text(input string s, input bit eoi_last);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.insert(q.size(), s[i]);
		send_bytes(q, eoi_last);
	endtask

	task automatic wait_all_results();
		push <= 1'b0;
		do @(posedge clk); while (due_words.size() != 0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return "0" + n;
		return ($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom); while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BACKSLASH);
		return c;
	endfunction

	function automatic logic [15:0] pick_code();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2: return 16'($urandom_range(16'h0800, 16'hFFFF));
			3: return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
			4: return 16'($urandom_range(LOW_FIRST, LOW_LAST));
			default: return 16'($urandom);
		endcase
	endfunction

	// Appends a \u escape; the digit at bad_pos (0..3) is replaced by a non-hex byte.
	task automatic add_u(ref byte_q_t q, input logic [15:0] v, input int bad_pos);
		logic [7:0] c;
		q.insert(q.size(), jsu_pkg::CH_BACKSLASH);
		q.insert(q.size(), jsu_pkg::CH_LC_U);
		for (int i = 0; i < 4; i++) begin
			if (i == bad_pos) begin
				do c = 8'($urandom); while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f")
					|| (c >= "A" && c <= "F"));
			end else begin
				c = hex_char(v[15 - 4 * i -: 4]);
			end
			q.insert(q.size(), c);
		end
	endtask

	task automatic add_piece(ref byte_q_t q);
		logic [7:0] c;
		case ($urandom_range(0, 11))
			0, 1, 2, 3: q.insert(q.size(), plain_char());
			4, 5: begin
				case ($urandom_range(0, 8))
					0: c = jsu_pkg::CH_LC_N;
					1: c = jsu_pkg::CH_LC_R;
					2: c = jsu_pkg::CH_LC_T;
					3: c = jsu_pkg::CH_LC_B;
					4: c = jsu_pkg::CH_LC_F;
					5: c = jsu_pkg::CH_QUOTE;
					6: c = jsu_pkg::CH_BACKSLASH;
					7: c = CH_SLASH;
					default: do c = 8'($urandom); while (c == jsu_pkg::CH_LC_U);
				endcase
				q.insert(q.size(), jsu_pkg::CH_BACKSLASH);
				q.insert(q.size(), c);
			end
			6, 7: add_u(q, pick_code(), 4);
			8: begin
				add_u(q, 16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 4);
				add_u(q, 16'($urandom_range(LOW_FIRST, LOW_LAST)),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4);
			end
			9: begin
				add_u(q, 16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 4);
				add_u(q, pick_code(), 4);
			end
			10: begin
				add_u(q, 16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 4);
				if ($urandom_range(0, 1)) begin
					do c = plain_char(); while (c == jsu_pkg::CH_QUOTE);
					q.insert(q.size(), c);
				end else begin
					do c = 8'($urandom); while (c == jsu_pkg::CH_LC_U);
					q.insert(q.size(), jsu_pkg::CH_BACKSLASH);
					q.insert(q.size(), c);
				end
			end
			default: add_u(q, pick_code(), $urandom_range(0, 3));
		endcase
	endtask

	task automatic test_outside_string();
		jsu_pkg::in_word_t w;
		w.in_byte = 8'h00;
		w.end_of_input = 1'b0;
		send_word(w);
		w.in_byte = 8'hFF;
		w.end_of_input = 1'b1;
		send_word(w);
		send_text("\"", 1'b1);
	endtask

	task automatic test_plain_escapes();
		jsu_pkg::in_word_t w;
		send_text("\"\\n\\r\\t\\b\\f\\/", 1'b0);
		w.end_of_input = 1'b0;
		w.in_byte = 8'h00;
		send_word(w);
		w.in_byte = 8'hFF;
		send_word(w);
		send_text("\"", 1'b0);
	endtask

	task automatic test_unicode_escapes();
		send_text("\"\\u00e9\\uD83D\\uDE00\\u12G4\"", 1'b0);
	endtask

	task automatic test_unterminated();
		send_text("\"ab", 1'b1);
		send_text("\"\\u12", 1'b1);
	endtask

	// The receiver holds off while a string of three-byte escapes streams in.
	task automatic test_backpressure();
		byte_q_t q;
		hold_request = 1'b1;
		no_gaps = 1'b1;
		q.insert(q.size(), jsu_pkg::CH_QUOTE);
		repeat (24) add_u(q, 16'h20AC, 4);
		q.insert(q.size(), jsu_pkg::CH_QUOTE);
		send_bytes(q, 1'b0);
		no_gaps = 1'b0;
		wait_all_results();
	endtask

	task automatic test_random_strings();
		byte_q_t q;
		int sent;
		int cut;
		bit eoi_last;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			q.delete();
			eoi_last = 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					logic [7:0] c;
					do c = 8'($urandom); while (c == jsu_pkg::CH_QUOTE);
					q.insert(q.size(), c);
				end
				eoi_last = 1'($urandom_range(0, 1));
			end else begin
				q.insert(q.size(), jsu_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 6)) add_piece(q);
				q.insert(q.size(), jsu_pkg::CH_QUOTE);
				if ($urandom_range(0, 5) == 0) begin
					cut = $urandom_range(0, q.size() - 1);
					q = q[0:cut];
					eoi_last = 1'b1;
				end
			end
			send_bytes(q, eoi_last);
			sent += q.size();
			if ($urandom_range(0, 39) == 0)
				wait_all_results();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_outside_string();
		test_plain_escapes();
		test_unicode_escapes();
		test_unterminated();
		wait_all_results();
		test_backpressure();
		test_random_strings();

		push <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && due_words.size() != 0; i++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (due_words.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, due_words.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
